// ===== src/sllm_pkg.sv =====
// shared types and constants for the static linked list manager
package sllm_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned InDataW = 40;

  typedef enum logic [1:0] {
    MODE_APPEND   = 2'd0,
    MODE_INSERT   = 2'd1,
    MODE_TRAVERSE = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

// ===== src/static_linked_list_manager.sv =====
// static linked list manager: array-based list with free slots, append, insert and traverse
//
//  channel | ports     | tdata                                     | tuser       | tlast
//  in      | in_t*     | [31:0] value_in, [37:32] position, rest 0 | [1:0] mode  | -
//  out     | out_t*    | [31:0] value_out                          | [1:0] status| last
//
//  append: new slot write, then tail link write; insert: one link memory read per hop,
//  then new slot and link writes; traverse: one slot per cycle from the link and value
//  memories while results are taken; error, empty and unused-mode requests skip to S_FIN.
//  no clearing pass: per-slot valid bits give the reset links at once after reset.
//  a stalled result holds the block in place; the next request waits for the current one.
module static_linked_list_manager
  import sllm_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // value_in, position, zero fill
  input  logic [1:0]          in_tuser,   // mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ValueW-1:0]   out_tdata,  // value_out
  output logic [1:0]          out_tuser,  // status
  output logic                out_tlast
);

  localparam int unsigned LW   = $clog2(SLOTS);
  localparam int unsigned CW   = PosW + 1;
  localparam logic [LW-1:0] HEAD = LW'(SLOTS - 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(SLOTS - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_NEW,
    S_APP_LINK,
    S_INS_WALK,
    S_INS_LINK,
    S_TRV_HEAD,
    S_TRV_EMIT,
    S_FIN
  } state_t;

  function automatic logic [LW-1:0] rst_link(input logic [LW-1:0] a);
    logic [LW-1:0] r;
    if (a == HEAD) r = '0;
    else r = a + LW'(1);
    return r;
  endfunction

  // memories
  logic [LW-1:0]     next_mem [SLOTS];
  logic [ValueW-1:0] val_mem  [SLOTS];
  logic [LW-1:0]     nq_r;
  logic [ValueW-1:0] vq_r;

  logic              rd_en;
  logic [LW-1:0]     rd_addr;
  logic              nwe;
  logic [LW-1:0]     nwaddr;
  logic [LW-1:0]     nwdata;
  logic              vwe;

  state_t            state_r, state_nxt;
  logic [SLOTS-1:0]  vld_r, vld_nxt;
  logic [LW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     tail_r, tail_nxt;
  logic [LW-1:0]     x_r, x_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic [ValueW-1:0] value_r, value_nxt;
  logic [1:0]        fin_st_r, fin_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LW-1:0]     link;
  logic [LW-1:0]     new_slot;
  logic              out_free;
  logic              full;
  logic [PosW-1:0]   in_pos;
  mode_t             in_mode;

  always_ff @(posedge clk) begin
    if (nwe) next_mem[nwaddr] <= nwdata;
    if (rd_en) nq_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vwe) val_mem[new_slot] <= value_r;
    if (rd_en) vq_r <= val_mem[rd_addr];
  end

  assign link     = vld_r[rd_addr_r] ? nq_r : rst_link(rd_addr_r);
  assign new_slot = len_r + LW'(1);
  assign full     = (len_r == MAX_LEN);
  assign out_free = !out_valid_r || out_tready;
  assign in_pos   = in_tdata[ValueW +: PosW];
  assign in_mode  = mode_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    vld_nxt        = vld_r;
    rd_addr_nxt    = rd_addr_r;
    len_nxt        = len_r;
    tail_nxt       = tail_r;
    x_nxt          = x_r;
    cnt_nxt        = cnt_r;
    value_nxt      = value_r;
    fin_st_nxt     = fin_st_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = HEAD;
    nwe            = 1'b0;
    nwaddr         = new_slot;
    nwdata         = '0;
    vwe            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          value_nxt = in_tdata[ValueW-1:0];
          unique case (in_mode)
            MODE_APPEND: begin
              if (full) begin
                fin_st_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_APP_NEW;
              end
            end
            MODE_INSERT: begin
              if (in_pos == '0 || CW'(in_pos) > CW'(len_r) + CW'(1)) begin
                fin_st_nxt = ST_BADPOS;
                state_nxt  = S_FIN;
              end else if (full) begin
                fin_st_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = HEAD;
                rd_addr_nxt = HEAD;
                x_nxt       = HEAD;
                cnt_nxt     = LW'(in_pos - PosW'(1));
                state_nxt   = S_INS_WALK;
              end
            end
            MODE_TRAVERSE: begin
              if (len_r == '0) begin
                fin_st_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = HEAD;
                rd_addr_nxt = HEAD;
                state_nxt   = S_TRV_HEAD;
              end
            end
            MODE_NONE: begin
              fin_st_nxt = ST_OK;
              state_nxt  = S_FIN;
            end
          endcase
        end
      end

      S_APP_NEW: begin
        nwe                = 1'b1;
        nwaddr             = new_slot;
        nwdata             = '0;
        vwe                = 1'b1;
        vld_nxt[new_slot]  = 1'b1;
        state_nxt          = S_APP_LINK;
      end

      S_APP_LINK: begin
        nwe              = 1'b1;
        nwaddr           = tail_r;
        nwdata           = new_slot;
        vld_nxt[tail_r]  = 1'b1;
        tail_nxt         = new_slot;
        len_nxt          = new_slot;
        fin_st_nxt       = ST_OK;
        state_nxt        = S_FIN;
      end

      S_INS_WALK: begin
        if (cnt_r == '0) begin
          nwe               = 1'b1;
          nwaddr            = new_slot;
          nwdata            = link;
          vwe               = 1'b1;
          vld_nxt[new_slot] = 1'b1;
          state_nxt         = S_INS_LINK;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = link;
          rd_addr_nxt = link;
          x_nxt       = link;
          cnt_nxt     = cnt_r - LW'(1);
        end
      end

      S_INS_LINK: begin
        nwe           = 1'b1;
        nwaddr        = x_r;
        nwdata        = new_slot;
        vld_nxt[x_r]  = 1'b1;
        if (x_r == tail_r) tail_nxt = new_slot;
        len_nxt       = new_slot;
        fin_st_nxt    = ST_OK;
        state_nxt     = S_FIN;
      end

      S_TRV_HEAD: begin
        rd_en       = 1'b1;
        rd_addr     = link;
        rd_addr_nxt = link;
        state_nxt   = S_TRV_EMIT;
      end

      S_TRV_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = vq_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = (link == '0);
          if (link == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = link;
            rd_addr_nxt = link;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = fin_st_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      len_r       <= '0;
      tail_r      <= HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      len_r       <= len_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r    <= rd_addr_nxt;
    x_r          <= x_nxt;
    cnt_r        <= cnt_nxt;
    value_r      <= value_nxt;
    fin_st_r     <= fin_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== test/tb_static_linked_list_manager.sv =====
// testbench for the static linked list manager: append, insert and traverse requests checked against a local list model
module tb_static_linked_list_manager;
  import sllm_pkg::*;

  localparam int unsigned SLOTS         = 32;
  localparam int unsigned LIST_HEAD     = SLOTS - 1;
  localparam int unsigned CAPACITY      = SLOTS - 2;
  localparam int unsigned RANDOM_ITEMS  = 210;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_t           status;
    logic              is_final;
  } list_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [ValueW-1:0]   out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;

  logic [4:0]          link_mem [SLOTS];
  logic [ValueW-1:0]   data_mem [SLOTS];
  list_result_t        pending_results [$];
  list_result_t        oldest;

  int unsigned         mismatches;
  int unsigned         results_checked;
  int unsigned         random_sent;
  int unsigned         sent_per_mode [4];
  int unsigned         quiet_cycles;
  int unsigned         hold_left;
  bit                  calm_stretch;

  static_linked_list_manager #(.SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value_in, position, zero fill
    .in_tuser   (in_tuser),   // mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // value_out
    .out_tuser  (out_tuser),  // status
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // list model
  function automatic void model_reset();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      link_mem[i] = 5'(i + 1);
      data_mem[i] = '0;
    end
    link_mem[LIST_HEAD] = '0;
  endfunction

  function automatic int unsigned model_length();
    int unsigned n;
    int unsigned x;
    n = 0;
    x = link_mem[LIST_HEAD];
    while (x != 0 && n < SLOTS) begin
      n++;
      x = link_mem[x];
    end
    return n;
  endfunction

  function automatic int unsigned take_free_slot();
    int unsigned a;
    a = link_mem[0];
    if (a == 0 || a == LIST_HEAD) return 0;
    link_mem[0] = link_mem[a];
    return a;
  endfunction

  function automatic void push_result(logic [ValueW-1:0] v, status_t st, logic fin);
    list_result_t r;
    r.value    = v;
    r.status   = st;
    r.is_final = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_results(mode_t m, logic [ValueW-1:0] v, logic [PosW-1:0] p);
    int unsigned a;
    int unsigned x;
    int unsigned nx;
    int unsigned n;
    int unsigned len;
    case (m)
      MODE_APPEND: begin
        a = take_free_slot();
        if (a == 0) begin
          push_result('0, ST_FULL, 1'b1);
        end else begin
          data_mem[a] = v;
          link_mem[a] = '0;
          x = LIST_HEAD;
          n = 0;
          while (link_mem[x] != 0 && n < SLOTS) begin
            x = link_mem[x];
            n++;
          end
          link_mem[x] = 5'(a);
          push_result('0, ST_OK, 1'b1);
        end
      end
      MODE_INSERT: begin
        len = model_length();
        if (p < 1 || p > len + 1) begin
          push_result('0, ST_BADPOS, 1'b1);
        end else begin
          a = take_free_slot();
          if (a == 0) begin
            push_result('0, ST_FULL, 1'b1);
          end else begin
            data_mem[a] = v;
            x = LIST_HEAD;
            for (int unsigned k = 1; k < p; k++) x = link_mem[x];
            link_mem[a] = link_mem[x];
            link_mem[x] = 5'(a);
            push_result('0, ST_OK, 1'b1);
          end
        end
      end
      MODE_TRAVERSE: begin
        x = link_mem[LIST_HEAD];
        if (x == 0) begin
          push_result('0, ST_EMPTY, 1'b1);
        end else begin
          n = 0;
          while (x != 0 && n < SLOTS) begin
            nx = link_mem[x];
            push_result(data_mem[x], ST_OK, nx == 0);
            n++;
            x = nx;
          end
          pending_results[pending_results.size() - 1].is_final = 1'b1;
        end
      end
      default: push_result('0, ST_OK, 1'b1);
    endcase
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic send_request(input mode_t m, input logic [ValueW-1:0] v,
                              input logic [PosW-1:0] p);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - PosW - ValueW){1'b0}}, p, v};
    in_tuser  <= m;
    predict_results(m, v, p);
    sent_per_mode[m]++;
    @(posedge clk iff in_tready);
  endtask

  task automatic send_random_request();
    int unsigned r;
    int unsigned len;
    logic [PosW-1:0] p;
    len = model_length();
    r = $urandom_range(0, 99);
    p = PosW'($urandom);
    if (r < 40) begin
      send_request(MODE_APPEND, random_value(), p);
    end else if (r < 75) begin
      if ($urandom_range(0, 4) != 0) p = PosW'($urandom_range(1, len + 1));
      else if ($urandom_range(0, 1) == 0) p = '0;
      else p = PosW'($urandom_range(len + 2, 63));
      send_request(MODE_INSERT, random_value(), p);
    end else if (r < 93) begin
      send_request(MODE_TRAVERSE, random_value(), p);
    end else begin
      send_request(MODE_NONE, random_value(), p);
    end
    random_sent++;
    if (random_sent % 40 == 0) calm_stretch = ($urandom_range(0, 3) == 0);
  endtask

  task automatic test_empty_list();
    send_request(MODE_TRAVERSE, '0, '0);
    send_request(MODE_NONE, 32'h1234_5678, 6'd5);
    send_request(MODE_INSERT, 32'h1111_1111, 6'd0);
    send_request(MODE_INSERT, 32'h2222_2222, 6'd2);
    send_request(MODE_INSERT, 32'h3333_3333, 6'd63);
  endtask

  task automatic test_edges();
    send_request(MODE_APPEND, 32'h7fff_ffff, '0);
    send_request(MODE_APPEND, 32'h8000_0000, '1);
    send_request(MODE_INSERT, 32'h0000_0000, 6'd1);
    send_request(MODE_INSERT, 32'hffff_ffff, 6'd4);
    send_request(MODE_INSERT, 32'ha5a5_5a5a, 6'd3);
    send_request(MODE_INSERT, 32'h5a5a_a5a5, 6'd0);
    send_request(MODE_INSERT, 32'h0f0f_0f0f, 6'd7);
    send_request(MODE_TRAVERSE, '0, '0);
    send_request(MODE_NONE, '1, '1);
  endtask

  task automatic test_random_fill();
    while (model_length() < CAPACITY) send_random_request();
  endtask

  task automatic test_full_store();
    send_request(MODE_APPEND, 32'hdead_beef, '0);
    send_request(MODE_INSERT, 32'hcafe_f00d, 6'd1);
    send_request(MODE_INSERT, 32'h0bad_cafe, 6'(CAPACITY + 1));
    send_request(MODE_INSERT, 32'h0000_0001, 6'(CAPACITY + 2));
    send_request(MODE_INSERT, 32'h0000_0002, 6'd0);
    send_request(MODE_TRAVERSE, '0, '0);
  endtask

  task automatic test_random_full();
    while (random_sent < RANDOM_ITEMS) send_random_request();
  endtask

  task automatic stop_requests();
    in_tvalid <= 1'b0;
  endtask

  // result side: random back-pressure
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
        hold_left = idle_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata !== oldest.value) report_mismatch("value_out", out_tdata, oldest.value);
        if (out_tuser !== oldest.status)
          report_mismatch("status", 32'(out_tuser), 32'(oldest.status));
        if (out_tlast !== oldest.is_final)
          report_mismatch("last", 32'(out_tlast), 32'(oldest.is_final));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("tb_static_linked_list_manager NOT OK");
        $finish;
      end
    end
  end

  initial begin
    mismatches      = 0;
    results_checked = 0;
    random_sent     = 0;
    calm_stretch    = 1'b0;
    for (int i = 0; i < 4; i++) sent_per_mode[i] = 0;
    model_reset();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_APPEND;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edges();
    test_random_fill();
    test_full_store();
    test_random_full();
    stop_requests();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests: %0d append, %0d insert, %0d traverse, %0d unused mode",
             sent_per_mode[MODE_APPEND], sent_per_mode[MODE_INSERT],
             sent_per_mode[MODE_TRAVERSE], sent_per_mode[MODE_NONE]);
    $display("%0d results checked, %0d mismatches, list ended with %0d of %0d slots used",
             results_checked, mismatches, model_length(), CAPACITY);
    if (mismatches == 0) begin
      $display("tb_static_linked_list_manager OK");
    end else begin
      $display("tb_static_linked_list_manager NOT OK");
    end
    $finish;
  end

endmodule
